/* src/ebht_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ebht_pkg;

  localparam int BYTE_W     = 8;
  localparam int REG_W      = 13;
  localparam int HIST_DEPTH = 256;
  localparam int STATUS_W   = 2;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;
  localparam int REG_IDX_W  = 2;
  localparam int FIFO_DEPTH = 2;

  typedef logic [STATUS_W-1:0]  status_t;
  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  localparam status_t STATUS_PASS      = 2'd0;
  localparam status_t STATUS_REP_FAIL  = 2'd1;
  localparam status_t STATUS_PROP_FAIL = 2'd2;

  localparam reg_idx_t REG_REP_LIMIT  = 2'd0;
  localparam reg_idx_t REG_MIN_BLOCK  = 2'd1;
  localparam reg_idx_t REG_PROP_FLOOR = 2'd2;

  localparam logic [REG_W-1:0] REP_LIMIT_RST  = 13'd9;
  localparam logic [REG_W-1:0] MIN_BLOCK_RST  = 13'd64;
  localparam logic [REG_W-1:0] PROP_FLOOR_RST = 13'd16;

  // Threshold settings seen by the front end
  typedef struct packed {
    logic [REG_W-1:0] rep_limit;
    logic [REG_W-1:0] min_block;
    logic [REG_W-1:0] prop_floor;
  } ebht_cfg_t;

  // One classified word passed from front to back
  typedef struct packed {
    logic [BYTE_W-1:0] sample_byte;
    logic              last_byte;
    logic              test_en;
    logic              rep_fail;
    logic [REG_W-1:0]  longest_run;
    logic [REG_W-1:0]  block_length;
  } ebht_entry_t;

endpackage

`default_nettype wire

/* src/ebht_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface ebht_in_if import ebht_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] sample_byte;
  logic              last_byte;

  modport source (output valid, sample_byte, last_byte, input ready);
  modport sink   (input valid, sample_byte, last_byte, output ready);
endinterface

interface ebht_out_if import ebht_pkg::*; ();
  logic             valid;
  logic             ready;
  status_t          status;
  logic [REG_W-1:0] longest_run;
  logic [REG_W-1:0] top_count;
  logic [REG_W-1:0] block_length;

  modport source (output valid, status, longest_run, top_count, block_length, input ready);
  modport sink   (input valid, status, longest_run, top_count, block_length, output ready);
endinterface

`default_nettype wire

/* src/ebht_cfg_regs.sv */
`timescale 1ns / 1ps
`default_nettype none

module ebht_cfg_regs import ebht_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [APB_ADDR_W-1:0] cfg_paddr,
  input  wire logic [APB_DATA_W-1:0] cfg_pwdata,
  output      logic [APB_DATA_W-1:0] cfg_prdata,
  output      logic                  cfg_pready,
  output      ebht_cfg_t             cfg
);

  ebht_cfg_t cfg_r;
  ebht_cfg_t cfg_nxt;
  reg_idx_t  idx;
  logic      wr_en;

  assign idx        = cfg_paddr[APB_ADDR_W-1 -: REG_IDX_W];
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_REP_LIMIT:  cfg_nxt.rep_limit  = cfg_pwdata[REG_W-1:0];
        REG_MIN_BLOCK:  cfg_nxt.min_block  = cfg_pwdata[REG_W-1:0];
        REG_PROP_FLOOR: cfg_nxt.prop_floor = cfg_pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_REP_LIMIT:  cfg_prdata = APB_DATA_W'(cfg_r.rep_limit);
      REG_MIN_BLOCK:  cfg_prdata = APB_DATA_W'(cfg_r.min_block);
      REG_PROP_FLOOR: cfg_prdata = APB_DATA_W'(cfg_r.prop_floor);
      default:        cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rep_limit  <= REP_LIMIT_RST;
      cfg_r.min_block  <= MIN_BLOCK_RST;
      cfg_r.prop_floor <= PROP_FLOOR_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/ebht_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module ebht_front import ebht_pkg::*; #(
  parameter int MAX_BLOCK = 4096
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  ebht_in_if.sink      in_ch,
  input  wire ebht_cfg_t cfg,
  input  wire logic    q_full,
  output      logic    q_push,
  output      ebht_entry_t q_entry,
  output      logic [((($clog2(MAX_BLOCK + 1)) > REG_W) ? $clog2(MAX_BLOCK + 1) : REG_W)-1:0]
                       q_thr
);

  localparam int CW = $clog2(MAX_BLOCK + 1);
  localparam int WW = (CW > REG_W) ? CW : REG_W;
  localparam logic [CW-1:0] MAXV = CW'(MAX_BLOCK);

  logic [BYTE_W-1:0] prev_r;
  logic [CW-1:0]     run_r, best_r, tot_r;
  logic [CW-1:0]     run_inc, run_new, best_new, tot_new;
  logic [WW-1:0]     best_w, tot_w, frac_w, floor_w;
  logic              accept, same;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign q_push      = accept;

  always_comb begin
    // A zero run length marks the start of a block
    same     = (run_r != '0) && (in_ch.sample_byte == prev_r);
    run_inc  = (run_r >= MAXV) ? MAXV : run_r + CW'(1);
    run_new  = same ? run_inc : CW'(1);
    best_new = (run_new > best_r) ? run_new : best_r;
    tot_new  = (tot_r >= MAXV) ? MAXV : tot_r + CW'(1);

    best_w  = WW'(best_new);
    tot_w   = WW'(tot_new);
    frac_w  = WW'(tot_new >> 3);
    floor_w = WW'(cfg.prop_floor);

    q_entry.sample_byte  = in_ch.sample_byte;
    q_entry.last_byte    = in_ch.last_byte;
    q_entry.test_en      = tot_w >= WW'(cfg.min_block);
    q_entry.rep_fail     = best_w >= WW'(cfg.rep_limit);
    q_entry.longest_run  = best_w[REG_W-1:0];
    q_entry.block_length = tot_w[REG_W-1:0];
    q_thr                = (frac_w < floor_w) ? floor_w : frac_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      run_r  <= '0;
      best_r <= CW'(1);
      tot_r  <= '0;
    end else if (accept) begin
      prev_r <= in_ch.sample_byte;
      if (in_ch.last_byte) begin
        run_r  <= '0;
        best_r <= CW'(1);
        tot_r  <= '0;
      end else begin
        run_r  <= run_new;
        best_r <= best_new;
        tot_r  <= tot_new;
      end
    end
  end

endmodule

`default_nettype wire

/* src/ebht_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module ebht_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  input  wire logic         pop,
  output      logic         full,
  output      logic         head_valid,
  output      logic [W-1:0] head_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [W-1:0]  store_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [NW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full       = (cnt_r == NW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_data  = store_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + NW'(1);
        2'b01:   cnt_r <= cnt_r - NW'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

/* src/ebht_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module ebht_back import ebht_pkg::*; #(
  parameter int MAX_BLOCK = 4096
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    head_valid,
  input  wire ebht_entry_t head_entry,
  input  wire logic [((($clog2(MAX_BLOCK + 1)) > REG_W) ? $clog2(MAX_BLOCK + 1) : REG_W)-1:0]
                       head_thr,
  output      logic    pop,
  ebht_out_if.source   out_ch
);

  localparam int CW = $clog2(MAX_BLOCK + 1);
  localparam int WW = (CW > REG_W) ? CW : REG_W;
  localparam logic [CW-1:0] MAXV = CW'(MAX_BLOCK);

  logic [CW-1:0]         hist_mem_r [HIST_DEPTH];
  logic [HIST_DEPTH-1:0] vld_r, vld_nxt;

  logic          b_v_r;
  ebht_entry_t   b_ent_r;
  logic [WW-1:0] b_thr_r;
  logic [CW-1:0] rd_r, fwd_val_r, best_r;
  logic          fwd_sel_r;

  logic          out_v_r;
  status_t       out_status_r;
  logic [REG_W-1:0] out_run_r, out_top_r, out_len_r;

  logic [CW-1:0] old_cnt, new_cnt, best_new;
  logic [WW-1:0] best_w;
  logic          b_go, fwd_hit;
  status_t       status;

  always_comb begin
    // Forward the count written on the edge this word was read
    old_cnt  = fwd_sel_r ? fwd_val_r : (vld_r[b_ent_r.sample_byte] ? rd_r : '0);
    new_cnt  = (old_cnt >= MAXV) ? MAXV : old_cnt + CW'(1);
    best_new = (new_cnt > best_r) ? new_cnt : best_r;
    best_w   = WW'(best_new);

    priority if (!b_ent_r.test_en)         status = STATUS_PASS;
    else if (b_ent_r.rep_fail)             status = STATUS_REP_FAIL;
    else if (best_w > b_thr_r)             status = STATUS_PROP_FAIL;
    else                                   status = STATUS_PASS;

    b_go    = b_v_r && (!b_ent_r.last_byte || !out_v_r || out_ch.ready);
    pop     = head_valid && (!b_v_r || b_go);
    fwd_hit = b_go && !b_ent_r.last_byte && (b_ent_r.sample_byte == head_entry.sample_byte);

    vld_nxt = vld_r;
    if (b_go) begin
      if (b_ent_r.last_byte) begin
        vld_nxt = '0;
      end else begin
        vld_nxt[b_ent_r.sample_byte] = 1'b1;
      end
    end
  end

  // Histogram memory: one read and one write port
  always_ff @(posedge clk) begin
    if (b_go) begin
      hist_mem_r[b_ent_r.sample_byte] <= new_cnt;
    end
    if (pop) begin
      rd_r <= hist_mem_r[head_entry.sample_byte];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b_ent_r   <= head_entry;
      b_thr_r   <= head_thr;
      fwd_sel_r <= fwd_hit;
      fwd_val_r <= new_cnt;
    end
    if (b_go && b_ent_r.last_byte) begin
      out_status_r <= status;
      out_run_r    <= b_ent_r.longest_run;
      out_top_r    <= best_w[REG_W-1:0];
      out_len_r    <= b_ent_r.block_length;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r   <= 1'b0;
      vld_r   <= '0;
      best_r  <= '0;
      out_v_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      if (pop) begin
        b_v_r <= 1'b1;
      end else if (b_go) begin
        b_v_r <= 1'b0;
      end
      if (b_go) begin
        best_r <= b_ent_r.last_byte ? '0 : best_new;
      end
      if (b_go && b_ent_r.last_byte) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.longest_run  = out_run_r;
  assign out_ch.top_count    = out_top_r;
  assign out_ch.block_length = out_len_r;

endmodule

`default_nettype wire

/* src/entropy_block_health_test_core.sv */
// A last byte's verdict passes the queue, the back stage and the result register.
// Throughput: one byte per cycle while the result side takes words; the
// histogram read-modify-write and its one-word forward path set that rate.
// Reset (rst_n, synchronous, active low): thresholds to 9/64/16, histogram
// valid flags cleared at once, queue and pipeline emptied; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module entropy_block_health_test_core import ebht_pkg::*; #(
  parameter int MAX_BLOCK = 4096
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  ebht_in_if.sink                    in_ch,
  ebht_out_if.source                 out_ch,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [APB_ADDR_W-1:0] cfg_paddr,
  input  wire logic [APB_DATA_W-1:0] cfg_pwdata,
  output      logic [APB_DATA_W-1:0] cfg_prdata,
  output      logic                  cfg_pready
);

  // Counter width holds MAX_BLOCK itself; threshold width also covers the
  // 13-bit register values
  localparam int CW = $clog2(MAX_BLOCK + 1);
  localparam int WW = (CW > REG_W) ? CW : REG_W;
  localparam int EW = $bits(ebht_entry_t);
  localparam int QW = EW + WW;

  ebht_cfg_t     cfg;
  logic          q_push, q_full, q_pop, head_valid;
  ebht_entry_t   q_entry, head_entry;
  logic [WW-1:0] q_thr, head_thr;
  logic [QW-1:0] head_data;

  // Register file: thresholds; write only while the block is quiet (the block does not enforce it)
  ebht_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // Front: track runs and block length, settle the repetition verdict and
  // the proportion threshold for each word
  ebht_front #(.MAX_BLOCK(MAX_BLOCK)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .cfg     (cfg),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_entry),
    .q_thr   (q_thr)
  );

  // Short queue: lets the front keep taking bytes while the result waits, until it fills
  ebht_fifo #(.W(QW), .DEPTH(FIFO_DEPTH)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  ({q_thr, q_entry}),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  assign head_entry = head_data[EW-1:0];
  assign head_thr   = head_data[QW-1 -: WW];

  // Back: histogram update, top count, final verdict and result register
  ebht_back #(.MAX_BLOCK(MAX_BLOCK)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .head_thr   (head_thr),
    .pop        (q_pop),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

/* src/ebht_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module ebht_checker import ebht_pkg::*; #(
  parameter int MAX_BLOCK = 4096
) (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [REG_W-1:0] longest_run,
  input wire logic [REG_W-1:0] top_count,
  input wire logic [REG_W-1:0] block_length
);

  localparam bit NO_WRAP = (MAX_BLOCK < (1 << REG_W));

  // Hold a stalled word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Run and top count can never exceed the block length
  a_stats_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !NO_WRAP || (longest_run <= block_length && top_count <= block_length))
    else $error("run or count beyond block length");

  // Every block has at least one byte, one run and one counted value
  a_stats_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !NO_WRAP ||
                  (longest_run != '0 && top_count != '0 && block_length != '0))
    else $error("empty statistics in result");

endmodule

bind entropy_block_health_test_core ebht_checker #(.MAX_BLOCK(MAX_BLOCK)) u_ebht_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .longest_run  (out_ch.longest_run),
  .top_count    (out_ch.top_count),
  .block_length (out_ch.block_length)
);

`default_nettype wire

/* verif/tb_entropy_block_health_test_core.sv */
`timescale 1ns / 1ps

module tb_entropy_block_health_test_core;
  import ebht_pkg::*;

  // Saturation point of every per-block counter, passed to the block as well
  localparam int SAT_LIMIT     = 4096;
  // Generous ceiling on the whole run, several times the slowest legal run
  localparam int CYCLE_LIMIT   = 400000;
  // Settling wait after the last verdict, so the queue and pipeline are idle
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_ITEMS   = 240;
  localparam int LONG_BLOCK    = 200;

  // Address slot with no register behind it
  localparam reg_idx_t REG_UNUSED = 2'd3;

  // Styles of block content for the random part
  localparam int STYLE_UNIFORM  = 0;
  localparam int STYLE_CLUSTER  = 1;
  localparam int STYLE_RUNS     = 2;

  typedef struct packed {
    status_t          status;
    logic [REG_W-1:0] longest_run;
    logic [REG_W-1:0] top_count;
    logic [REG_W-1:0] block_length;
  } verdict_t;

  // Tracks the block statistics and holds the verdicts still owed by the block
  class health_scoreboard;
    logic [REG_W-1:0]  hist [HIST_DEPTH];
    logic [REG_W-1:0]  total;
    logic [REG_W-1:0]  run_len;
    logic [REG_W-1:0]  best_run;
    logic [REG_W-1:0]  best_count;
    logic [BYTE_W-1:0] prev_byte;
    logic [REG_W-1:0]  rep_limit;
    logic [REG_W-1:0]  min_block;
    logic [REG_W-1:0]  prop_floor;
    verdict_t          verdicts [$];
    int                errors;

    function new();
      clear_block();
      prev_byte  = '0;
      rep_limit  = REP_LIMIT_RST;
      min_block  = MIN_BLOCK_RST;
      prop_floor = PROP_FLOOR_RST;
      errors     = 0;
    endfunction

    function void clear_block();
      foreach (hist[i]) hist[i] = '0;
      total      = '0;
      run_len    = '0;
      best_run   = REG_W'(1);
      best_count = '0;
    endfunction

    function logic [REG_W-1:0] sat_inc(logic [REG_W-1:0] v);
      return (v >= REG_W'(SAT_LIMIT)) ? REG_W'(SAT_LIMIT) : v + 1'b1;
    endfunction

    function void write_reg(reg_idx_t idx, logic [APB_DATA_W-1:0] value);
      case (idx)
        REG_REP_LIMIT:  rep_limit  = value[REG_W-1:0];
        REG_MIN_BLOCK:  min_block  = value[REG_W-1:0];
        REG_PROP_FLOOR: prop_floor = value[REG_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_byte(logic [BYTE_W-1:0] b, logic last);
      verdict_t         v;
      logic [REG_W-1:0] threshold;
      if (run_len == '0 || b != prev_byte) run_len = REG_W'(1);
      else run_len = sat_inc(run_len);
      if (run_len > best_run) best_run = run_len;
      hist[b] = sat_inc(hist[b]);
      if (hist[b] > best_count) best_count = hist[b];
      total     = sat_inc(total);
      prev_byte = b;
      if (last) begin
        v.status = STATUS_PASS;
        if (total >= min_block) begin
          threshold = total / REG_W'(8);
          if (threshold < prop_floor) threshold = prop_floor;
          if (best_run >= rep_limit) v.status = STATUS_REP_FAIL;
          else if (best_count > threshold) v.status = STATUS_PROP_FAIL;
        end
        v.longest_run  = best_run;
        v.top_count    = best_count;
        v.block_length = total;
        verdicts.push_back(v);
        clear_block();
      end
    endfunction

    function void check_field(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(verdict_t got);
      verdict_t want;
      if (verdicts.size() == 0) begin
        $display("%0t: verdict with none expected: expected none, actual %0d/%0d/%0d/%0d",
                 $time, got.status, got.longest_run, got.top_count, got.block_length);
        errors++;
        return;
      end
      want = verdicts.pop_front();
      check_field("status", want.status, got.status);
      check_field("longest_run", want.longest_run, got.longest_run);
      check_field("top_count", want.top_count, got.top_count);
      check_field("block_length", want.block_length, got.block_length);
    endfunction

    function int pending();
      return verdicts.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [APB_ADDR_W-1:0] cfg_paddr;
  logic [APB_DATA_W-1:0] cfg_pwdata;
  logic [APB_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  ebht_in_if  in_ch ();
  ebht_out_if out_ch ();

  health_scoreboard sb = new();

  // Idle percentages of the sender and the receiver, changed between phases
  int src_idle;
  int sink_idle;
  int cycle_count;

  entropy_block_health_test_core #(
    .MAX_BLOCK(SAT_LIMIT)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  // Hold every input at a known value from time zero
  initial begin
    clk                = 1'b0;
    rst_n              = 1'b0;
    cfg_psel           = 1'b0;
    cfg_penable        = 1'b0;
    cfg_pwrite         = 1'b0;
    cfg_paddr          = '0;
    cfg_pwdata         = '0;
    in_ch.valid        = 1'b0;
    in_ch.sample_byte  = '0;
    in_ch.last_byte    = 1'b0;
    out_ch.ready       = 1'b0;
    src_idle           = 25;
    sink_idle          = 54;
    cycle_count        = 0;
  end

  // Stall the result side at random; change ready only on falling edges
  always @(negedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(99) >= sink_idle);
  end

  // Compare every verdict word taken from the block with the oldest expectation
  always @(posedge clk) begin : verdict_monitor
    verdict_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.status       = out_ch.status;
      got.longest_run  = out_ch.longest_run;
      got.top_count    = out_ch.top_count;
      got.block_length = out_ch.block_length;
      sb.check_result(got);
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_entropy_block_health_test_core: FAIL");
      $finish;
    end
  end

  // Offer one byte word, idling first at the sender's rate, and wait for it to be taken
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
    while ($urandom_range(99) < src_idle) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid       <= 1'b1;
    in_ch.sample_byte <= b;
    in_ch.last_byte   <= last;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_byte(b, last);
  endtask

  // Send a fixed sequence as one block, marking its final byte
  task automatic send_seq(input logic [BYTE_W-1:0] seq [$]);
    foreach (seq[i]) send_byte(seq[i], i == seq.size() - 1);
  endtask

  // Drop valid and hold until every verdict owed has come back
  task automatic wait_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Drain, then let the pipeline settle so a register write lands on an idle block
  task automatic wait_idle();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write with a setup phase, then an access phase; the register takes the value on the access edge
  task automatic write_reg(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.write_reg(idx, value);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic set_thresholds(input logic [APB_DATA_W-1:0] rep,
                                input logic [APB_DATA_W-1:0] min_len,
                                input logic [APB_DATA_W-1:0] floor_val);
    wait_idle();
    write_reg(REG_REP_LIMIT, rep);
    write_reg(REG_MIN_BLOCK, min_len);
    write_reg(REG_PROP_FLOOR, floor_val);
  endtask

  // One block of random content; clustered and run-heavy styles push the
  // repetition and proportion counters towards their thresholds
  task automatic send_random_block(input int len);
    int                style;
    int                spread;
    logic [BYTE_W-1:0] base;
    logic [BYTE_W-1:0] cur;
    logic [BYTE_W-1:0] b;
    style  = $urandom_range(STYLE_RUNS, STYLE_UNIFORM);
    spread = $urandom_range(3, 0);
    base   = BYTE_W'($urandom);
    cur    = BYTE_W'($urandom);
    for (int i = 0; i < len; i++) begin
      case (style)
        STYLE_CLUSTER: b = base + BYTE_W'($urandom_range(spread, 0));
        STYLE_RUNS: begin
          if ($urandom_range(3, 0) == 0) cur = BYTE_W'($urandom);
          b = cur;
        end
        default: b = BYTE_W'($urandom);
      endcase
      send_byte(b, i == len - 1);
    end
  endtask

  // Mostly short blocks, a tenth of them longer; now and then hold the
  // sender until the block has answered everything
  task automatic run_phase(input int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9, 0) == 0) len = $urandom_range(200, 41);
      else len = $urandom_range(40, 1);
      send_random_block(len);
      sent += len;
      if ($urandom_range(7, 0) == 0) wait_results();
    end
  endtask

  initial begin : stimulus
    logic [BYTE_W-1:0] seq [$];
    logic [BYTE_W-1:0] fill;

    // Single reset at the start, released on a falling edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset thresholds: a one-byte block is short and passes
    seq = {8'h00};
    send_seq(seq);

    // Ignored slot, then tight thresholds so short directed blocks get tested
    wait_idle();
    write_reg(REG_UNUSED, 32'h0000_0001);
    set_thresholds(32'd3, 32'd4, 32'd1);

    // Both tests fail: repetition must win
    seq = {8'hFF, 8'hFF, 8'hFF, 8'h00};
    send_seq(seq);
    // Proportion only
    seq = {8'h01, 8'h02, 8'h01, 8'h02, 8'h01};
    send_seq(seq);
    // Clean pass
    seq = {8'h00, 8'h01, 8'h02, 8'h03};
    send_seq(seq);
    // Short block with a failing run still passes
    seq = {8'h07, 8'h07, 8'h07};
    send_seq(seq);

    // Sender idles 25 %, receiver 54 %: lowest legal thresholds, then zeros
    set_thresholds(32'd2, 32'd1, 32'd1);
    run_phase(PHASE_ITEMS);
    set_thresholds(32'd0, 32'd0, 32'd0);
    run_phase(PHASE_ITEMS);

    // Swap the idle rates: random mid-range settings, then the top of range
    wait_idle();
    src_idle  = 54;
    sink_idle = 25;
    set_thresholds($urandom_range(10, 3), $urandom_range(50, 1), $urandom_range(12, 1));
    run_phase(PHASE_ITEMS);
    set_thresholds(32'd4096, 32'd4096, 32'd4096);
    run_phase(PHASE_ITEMS);

    // No idling: words with set upper bits exercise the unused upper bits
    wait_idle();
    src_idle  = 0;
    sink_idle = 0;
    set_thresholds(32'hFFFF_FFFF, $urandom_range(30, 1), 32'hFFFF_E001);
    run_phase(PHASE_ITEMS);
    set_thresholds(32'd1, $urandom_range(30, 1), $urandom_range(8, 0));
    run_phase(PHASE_ITEMS);

    // One long constant block: a single long run and one dominant count
    set_thresholds(32'd4096, 32'd4096, 32'd100);
    fill = BYTE_W'($urandom);
    for (int i = 0; i < LONG_BLOCK; i++) send_byte(fill, i == LONG_BLOCK - 1);

    wait_results();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_entropy_block_health_test_core: PASS");
    end else begin
      $display("tb_entropy_block_health_test_core: FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
src/ebht_pkg.sv
src/ebht_if.sv
src/ebht_cfg_regs.sv
src/ebht_front.sv
src/ebht_fifo.sv
src/ebht_back.sv
src/entropy_block_health_test_core.sv
src/ebht_checker.sv
verif/tb_entropy_block_health_test_core.sv
